[hw/rtl/assert_macros.svh]
// assertion macros used by the frame checker rtl
// no dependencies; expands to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/htfc_pkg.sv]
// types, constants and the crc-8 step of the humidity/temperature frame checker
// no dependencies
package htfc_pkg;

  typedef logic [2:0] status_t;
  typedef logic [1:0] cfg_index_t;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_RETRY   = 3'd1;
  localparam status_t ST_TIMEOUT = 3'd2;
  localparam status_t ST_BAD     = 3'd3;
  localparam status_t ST_RANGE   = 3'd4;

  localparam cfg_index_t CFG_MAX_ATTEMPTS = 2'd0;
  localparam cfg_index_t CFG_TEMP_MIN     = 2'd1;
  localparam cfg_index_t CFG_TEMP_MAX     = 2'd2;

  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [3:0]         MAX_ATTEMPTS_RST = 4'd4;
  localparam logic signed [14:0] TEMP_MIN_RST     = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX_RST     = 15'sd8500;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam int unsigned BUSY_BIT = 7;
  localparam int unsigned CAL_BIT  = 3;
  localparam logic [2:0] LAST_POS = 3'd6;
  localparam logic [3:0] ATTEMPT_SAT = 4'hF;

  localparam logic [13:0]        HUM_SCALE   = 14'd10000;
  localparam logic [14:0]        TEMP_SCALE  = 15'd20000;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd5000;

  // one byte of crc-8, msb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[hw/rtl/htfc_if.sv]
// valid/ready channels of the frame checker: frame bytes in, status results out
// depends on htfc_pkg
interface htfc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface htfc_out_if;
  logic                valid;
  logic                ready;
  htfc_pkg::status_t   status;
  logic [19:0]         humidity_raw;
  logic [19:0]         temperature_raw;
  logic [13:0]         humidity_centi;
  logic signed [14:0]  temperature_centi;

  modport source (output valid, status, humidity_raw, temperature_raw, humidity_centi,
                  temperature_centi, input ready);
  modport sink (input valid, status, humidity_raw, temperature_raw, humidity_centi,
                temperature_centi, output ready);
endinterface

[hw/rtl/humidity_temp_frame_checker.sv]
// humidity/temperature sensor frame checker: crc-8, status decode and scaling
// depends on htfc_pkg, htfc_if.sv and assert_macros.svh
`include "assert_macros.svh"

// Takes one beat per clock: a trigger (kind 0) restarts the measurement, a
// frame byte (kind 1) advances the 7-byte frame. Bytes 0 to 5 run through the
// crc-8 (poly 0x31, init 0xFF) and fill the status and raw accumulators; the
// seventh byte yields one result, registered, on the output channel in the
// next cycle. The scaling multipliers and the limit compare sit in that one
// stage, so a new beat is accepted each cycle;
// frame_in.ready drops only while a result is held and result_out is stalled.
module humidity_temp_frame_checker (
  input  logic                            clk,
  input  logic                            rst,
  htfc_in_if.sink                         frame_in,
  htfc_out_if.source                      result_out,
  input  logic                            cfg_we,
  input  htfc_pkg::cfg_index_t            cfg_index,
  input  logic [htfc_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [3:0]         max_attempts;
  logic signed [14:0] temp_min_centi;
  logic signed [14:0] temp_max_centi;

  // frame state
  logic [2:0]  pos;
  logic [7:0]  crc;
  logic [3:0]  attempt;
  logic [7:0]  stat_byte;
  logic [19:0] hum_acc;
  logic [19:0] temp_acc;

  // result register
  logic out_valid;

  logic               in_fire;
  logic               byte_beat;
  logic               frame_end;
  logic [3:0]         attempt_next;
  logic [33:0]        hum_prod;
  logic [34:0]        temp_prod;
  logic signed [15:0] temp_c;
  logic signed [15:0] tmin;
  logic signed [15:0] tmax;
  logic               out_of_range;
  logic               frame_bad;
  htfc_pkg::status_t  status_next;
  logic               ok_shown;
  logic               temp_in_window;

  assign frame_in.ready = !out_valid || result_out.ready;
  assign in_fire   = frame_in.valid && frame_in.ready;
  assign byte_beat = in_fire && frame_in.kind;
  assign frame_end = byte_beat && (pos == htfc_pkg::LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts   <= htfc_pkg::MAX_ATTEMPTS_RST;
      temp_min_centi <= htfc_pkg::TEMP_MIN_RST;
      temp_max_centi <= htfc_pkg::TEMP_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        htfc_pkg::CFG_MAX_ATTEMPTS: max_attempts <= cfg_data[3:0];
        htfc_pkg::CFG_TEMP_MIN:     temp_min_centi <= $signed(cfg_data);
        htfc_pkg::CFG_TEMP_MAX:     temp_max_centi <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign attempt_next = (attempt == htfc_pkg::ATTEMPT_SAT) ? attempt : attempt + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= 3'd0;
      crc     <= htfc_pkg::CRC_INIT;
      attempt <= 4'd0;
    end else if (in_fire) begin
      if (!frame_in.kind) begin
        pos     <= 3'd0;
        crc     <= htfc_pkg::CRC_INIT;
        attempt <= 4'd0;
      end else if (pos == htfc_pkg::LAST_POS) begin
        pos <= 3'd0;
        crc <= htfc_pkg::CRC_INIT;
        if (stat_byte[htfc_pkg::BUSY_BIT]) begin
          attempt <= attempt_next;
        end
      end else begin
        pos <= pos + 3'd1;
        crc <= htfc_pkg::crc8_update(crc, frame_in.data_byte);
      end
    end
  end

  // frame payload accumulators
  always_ff @(posedge clk) begin
    if (byte_beat && pos != htfc_pkg::LAST_POS) begin
      unique case (pos)
        3'd0: stat_byte <= frame_in.data_byte;
        3'd1: hum_acc <= {frame_in.data_byte, 12'd0};
        3'd2: hum_acc[11:4] <= frame_in.data_byte;
        3'd3: begin
          hum_acc[3:0] <= frame_in.data_byte[7:4];
          temp_acc     <= {frame_in.data_byte[3:0], 16'd0};
        end
        3'd4: temp_acc[15:8] <= frame_in.data_byte;
        default: temp_acc[7:0] <= frame_in.data_byte;
      endcase
    end
  end

  // scaling to hundredths: floor of raw * scale / 2^20, less TEMP_OFFSET for temperature
  assign hum_prod  = 34'(hum_acc) * 34'(htfc_pkg::HUM_SCALE);
  assign temp_prod = 35'(temp_acc) * 35'(htfc_pkg::TEMP_SCALE);
  assign temp_c    = $signed({1'b0, temp_prod[34:20]}) - htfc_pkg::TEMP_OFFSET;
  assign tmin      = 16'(temp_min_centi);
  assign tmax      = 16'(temp_max_centi);
  assign out_of_range = (temp_c < tmin) || (temp_c > tmax);
  assign frame_bad = !stat_byte[htfc_pkg::CAL_BIT] || (crc != frame_in.data_byte);

  always_comb begin
    priority if (stat_byte[htfc_pkg::BUSY_BIT]) begin
      status_next = (attempt_next >= max_attempts) ? htfc_pkg::ST_TIMEOUT
                                                   : htfc_pkg::ST_RETRY;
    end else if (frame_bad) begin
      status_next = htfc_pkg::ST_BAD;
    end else if (out_of_range) begin
      status_next = htfc_pkg::ST_RANGE;
    end else begin
      status_next = htfc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_end) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      result_out.status <= status_next;
      if (status_next == htfc_pkg::ST_OK || status_next == htfc_pkg::ST_RANGE) begin
        result_out.humidity_raw      <= hum_acc;
        result_out.temperature_raw   <= temp_acc;
        result_out.humidity_centi    <= hum_prod[33:20];
        result_out.temperature_centi <= temp_c[14:0];
      end else begin
        result_out.humidity_raw      <= 20'd0;
        result_out.temperature_raw   <= 20'd0;
        result_out.humidity_centi    <= 14'd0;
        result_out.temperature_centi <= 15'sd0;
      end
    end
  end

  assign result_out.valid = out_valid;

  assign ok_shown       = out_valid && (result_out.status == htfc_pkg::ST_OK);
  assign temp_in_window = (result_out.temperature_centi >= temp_min_centi) &&
                          (result_out.temperature_centi <= temp_max_centi);

  // a result only follows the seventh byte of a frame
  `ASSERT_IMPLIES(a_result_after_frame_end, clk, rst, $rose(out_valid), $past(frame_end))
  // a trigger restarts the frame
  `ASSERT_NEXT(a_trigger_clears_pos, clk, rst, in_fire && !frame_in.kind, pos == 3'd0)
  // an ok result carries a temperature inside the limits
  `ASSERT_IMPLIES(a_ok_in_range, clk, rst, ok_shown, temp_in_window)

endmodule
